// ===== sv/mmks_pkg.sv =====
// Shared types and constants of the multi-mode key store.
// No dependencies; imported by every module of the block.
package mmks_pkg;

  localparam int Depth = 16;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int KeyW  = 32;
  localparam int CfgW  = 5;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_SHOW   = 2'd2;

  // mode codes
  localparam logic [1:0] MODE_SORTED = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_STACK  = 2'd2;
  localparam logic [1:0] MODE_CIRC   = 2'd3;

  // configuration register indexes
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_CAP  = 1'b1;

  // result kind codes
  localparam logic KIND_REMOVED = 1'b0;
  localparam logic KIND_LISTED  = 1'b1;

  typedef struct packed {
    logic                   valid;
    logic signed [KeyW-1:0] value;
    logic                   kind;
    logic                   last;
  } res_t;

endpackage

// ===== sv/mmks_engine.sv =====
// Sequencer and slot memory of the key store for all four modes, with
// read-modify-write walks over the slots in sorted mode. Depends on mmks_pkg.
module mmks_engine import mmks_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_clr_i,
  input  logic [1:0]             mode_i,
  input  logic [CntW-1:0]        cap_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             action_i,
  input  logic signed [KeyW-1:0] key_i,
  input  logic                   out_ready_i,
  output res_t                   push_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EMIT = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_SHOW = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d, ptr_q, ptr_d;
  logic [CntW-1:0] occ_q, occ_d, idx_q, idx_d;
  logic            ins_q, ins_d, shift_q, shift_d;
  logic [KeyW-1:0] key_q, key_d, carry_q, carry_d;

  logic [KeyW-1:0] mem [Depth];
  logic [KeyW-1:0] rdata_q;
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_wa, mem_ra;
  logic [KeyW-1:0] mem_wd;

  logic [CntW-1:0] idx_nxt, head_p1, tail_p1, ptr_p1;
  logic [IdxW-1:0] head_w, tail_w, ptr_w, ptr_nxt;
  logic            queue_mode, show_last;

  assign idx_nxt    = idx_q + CntW'(1);
  assign head_p1    = CntW'(head_q) + CntW'(1);
  assign tail_p1    = CntW'(tail_q) + CntW'(1);
  assign ptr_p1     = CntW'(ptr_q) + CntW'(1);
  // wrap at the configured capacity for the circular queue
  assign head_w     = (head_p1 == cap_i) ? '0 : head_p1[IdxW-1:0];
  assign tail_w     = (tail_p1 == cap_i) ? '0 : tail_p1[IdxW-1:0];
  assign ptr_w      = (ptr_p1 == cap_i) ? '0 : ptr_p1[IdxW-1:0];
  assign ptr_nxt    = (mode_i == MODE_CIRC) ? ptr_w : ptr_p1[IdxW-1:0];
  assign queue_mode = (mode_i == MODE_LINEAR) || (mode_i == MODE_CIRC);
  assign show_last  = (idx_nxt == occ_q);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    ptr_d   = ptr_q;
    occ_d   = occ_q;
    idx_d   = idx_q;
    ins_d   = ins_q;
    shift_d = shift_q;
    key_d   = key_q;
    carry_d = carry_q;
    mem_we  = 1'b0;
    mem_wa  = idx_q[IdxW-1:0];
    mem_wd  = carry_q;
    mem_re  = 1'b0;
    mem_ra  = idx_nxt[IdxW-1:0];
    push_o  = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d   = key_i;
          carry_d = key_i;
          shift_d = 1'b0;
          idx_d   = '0;
          ins_d   = (action_i == ACT_INSERT);
          case (action_i)
            ACT_INSERT: begin
              case (mode_i)
                MODE_SORTED: begin
                  if (occ_q < cap_i) begin
                    state_d = S_SCAN;
                    mem_re  = 1'b1;
                    mem_ra  = '0;
                  end
                end
                MODE_LINEAR: begin
                  if (occ_q == '0) begin
                    head_d = '0;
                    tail_d = '0;
                    mem_we = 1'b1;
                    mem_wa = '0;
                    mem_wd = key_i;
                    occ_d  = occ_q + CntW'(1);
                  end else if (tail_p1 < cap_i) begin
                    tail_d = tail_p1[IdxW-1:0];
                    mem_we = 1'b1;
                    mem_wa = tail_p1[IdxW-1:0];
                    mem_wd = key_i;
                    occ_d  = occ_q + CntW'(1);
                  end
                end
                MODE_STACK: begin
                  if (occ_q < cap_i) begin
                    mem_we = 1'b1;
                    mem_wa = occ_q[IdxW-1:0];
                    mem_wd = key_i;
                    occ_d  = occ_q + CntW'(1);
                  end
                end
                default: begin
                  // circular queue keeps one slot free
                  if ((occ_q + CntW'(1)) < cap_i) begin
                    mem_we = 1'b1;
                    mem_wd = key_i;
                    occ_d  = occ_q + CntW'(1);
                    if (occ_q == '0) begin
                      head_d = '0;
                      tail_d = '0;
                      mem_wa = '0;
                    end else begin
                      tail_d = tail_w;
                      mem_wa = tail_w;
                    end
                  end
                end
              endcase
            end
            ACT_REMOVE: begin
              if (occ_q != '0) begin
                mem_re = 1'b1;
                if (mode_i == MODE_SORTED) begin
                  state_d = S_SCAN;
                  mem_ra  = '0;
                end else if (mode_i == MODE_STACK) begin
                  state_d = S_POP;
                  mem_ra  = occ_d[IdxW-1:0] - IdxW'(1);
                end else begin
                  state_d = S_POP;
                  mem_ra  = head_q;
                end
              end
            end
            ACT_SHOW: begin
              if (occ_q != '0) begin
                state_d = S_SHOW;
                ptr_d   = queue_mode ? head_q : '0;
                mem_re  = 1'b1;
                mem_ra  = queue_mode ? head_q : '0;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (ins_q) begin
          // walk up; once past the insert point every slot shifts up by one
          if (idx_q == occ_q) begin
            mem_we  = 1'b1;
            occ_d   = occ_q + CntW'(1);
            state_d = S_IDLE;
          end else if (!shift_q && (rdata_q == key_q)) begin
            state_d = S_IDLE;
          end else if (!shift_q && ($signed(rdata_q) < $signed(key_q))) begin
            idx_d  = idx_nxt;
            mem_re = 1'b1;
          end else begin
            mem_we  = 1'b1;
            carry_d = rdata_q;
            shift_d = 1'b1;
            idx_d   = idx_nxt;
            mem_re  = 1'b1;
          end
        end else begin
          // find the key, then move each later slot down by one
          if (idx_q == occ_q) begin
            state_d = shift_q ? S_EMIT : S_IDLE;
          end else begin
            idx_d  = idx_nxt;
            mem_re = 1'b1;
            if (shift_q) begin
              mem_we = 1'b1;
              mem_wa = idx_q[IdxW-1:0] - IdxW'(1);
              mem_wd = rdata_q;
            end else if (rdata_q == key_q) begin
              shift_d = 1'b1;
              carry_d = rdata_q;
            end
          end
        end
      end

      S_EMIT: begin
        if (out_ready_i) begin
          push_o  = '{valid: 1'b1, value: carry_q, kind: KIND_REMOVED, last: 1'b1};
          occ_d   = occ_q - CntW'(1);
          state_d = S_IDLE;
        end
      end

      S_POP: begin
        if (out_ready_i) begin
          push_o  = '{valid: 1'b1, value: rdata_q, kind: KIND_REMOVED, last: 1'b1};
          occ_d   = occ_q - CntW'(1);
          state_d = S_IDLE;
          if (queue_mode) begin
            if (occ_q == CntW'(1)) begin
              head_d = '0;
              tail_d = '0;
            end else begin
              head_d = (mode_i == MODE_CIRC) ? head_w : head_p1[IdxW-1:0];
            end
          end
        end
      end

      S_SHOW: begin
        // rdata holds while the output waits, since no new read is issued
        if (out_ready_i) begin
          push_o = '{valid: 1'b1, value: rdata_q, kind: KIND_LISTED, last: show_last};
          if (show_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d  = idx_nxt;
            ptr_d  = ptr_nxt;
            mem_re = 1'b1;
            mem_ra = ptr_nxt;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (cfg_clr_i) begin
      head_d = '0;
      tail_d = '0;
      occ_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    idx_q   <= idx_d;
    ins_q   <= ins_d;
    shift_q <= shift_d;
    key_q   <= key_d;
    carry_q <= carry_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

endmodule

// ===== sv/mmks_obuf.sv =====
// Output register of the key store: holds one result item until taken.
// Depends on mmks_pkg.
module mmks_obuf import mmks_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  res_t                   push_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [KeyW-1:0] value_o,
  output logic                   kind_o,
  output logic                   last_o
);

  logic                   valid_q, valid_d;
  logic signed [KeyW-1:0] value_q;
  logic                   kind_q, last_q;

  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = push_i.valid || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      value_q <= push_i.value;
      kind_q  <= push_i.kind;
      last_q  <= push_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign value_o     = value_q;
  assign kind_o      = kind_q;
  assign last_o      = last_q;

endmodule

// ===== sv/multi_mode_key_store.sv =====
// Multi-mode key store: a 16-slot store of signed 32-bit keys working as a
// sorted list, linear queue, stack or circular queue, selected by the mode
// register. Slots live in one memory with a single registered read port, and
// every slot read goes through it. Inserts in queue and stack modes write the
// slot directly from idle; a queue or stack remove reads the slot, then
// waits in the pop state until the output takes it. A sorted insert or
// remove walks the occupied slots in order. Show emits one result item per
// cycle while the output is not stalled. The output register lets a new item
// be accepted while the last result waits. Writing mode or capacity empties
// the store; write them only while the block is idle.
module multi_mode_key_store import mmks_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [CfgW-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             action_i,
  input  logic signed [KeyW-1:0] key_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [KeyW-1:0] value_o,
  output logic                   kind_o,
  output logic                   last_o
);

  logic [1:0]      mode_q, mode_d;
  logic [CfgW-1:0] cap_q, cap_d;
  logic [CntW-1:0] eff_cap;
  logic            out_ready;
  res_t            push;

  always_comb begin
    mode_d = mode_q;
    cap_d  = cap_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE: mode_d = cfg_data_i[1:0];
        CFG_CAP:  cap_d  = cfg_data_i;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SORTED;
      cap_q  <= CfgW'(16);
    end else begin
      mode_q <= mode_d;
      cap_q  <= cap_d;
    end
  end

  // zero means one, anything above the depth means the depth
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CntW'(1);
    end else if (32'(cap_q) > Depth) begin
      eff_cap = CntW'(Depth);
    end else begin
      eff_cap = CntW'(cap_q);
    end
  end

  mmks_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_clr_i   (cfg_we_i),
    .mode_i      (mode_q),
    .cap_i       (eff_cap),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .key_i       (key_i),
    .out_ready_i (out_ready),
    .push_o      (push)
  );

  mmks_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .kind_o      (kind_o),
    .last_o      (last_o)
  );

endmodule
